// File: src/lik_pkg.sv
package lik_pkg;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_ABD_OFFSET = 2'd0,
    CFG_UPPER_LEN  = 2'd1,
    CFG_LOWER_LEN  = 2'd2
  } cfg_reg_t;

  localparam logic [15:0] ABD_OFFSET_RST = 16'd4063;
  localparam logic [15:0] UPPER_LEN_RST  = 16'd13697;
  localparam logic [15:0] LOWER_LEN_RST  = 16'd12780;

  // square root cells: wide one for leg lengths, narrow one inside acos
  localparam int SQ_WIDE_W   = 18;
  localparam int SQ_NARROW_W = 17;

  // restoring divider for acos arguments
  localparam int DIV_W = 35;
  localparam int QW    = 17;

  // atan2 unit
  localparam int ATAN_IN_W    = 18;
  localparam int ANG_W        = 17;
  localparam int NORM_W       = 31;
  localparam int NORM_STEPS   = 5;
  localparam int CORDIC_W     = 35;
  localparam int Z_W          = 19;
  localparam int CORDIC_STEPS = 16;
  localparam int LAT_ATAN     = NORM_STEPS + CORDIC_STEPS + 1;

  localparam logic [17:0]           PI_Q16      = 18'd205887;
  localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 19'sd102944;
  localparam logic [33:0]           ONE_SQ      = 34'h1_0000_0000;

  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    19'sd51472, 19'sd30386, 19'sd16055, 19'sd8150, 19'sd4091, 19'sd2047,
    19'sd1024, 19'sd512, 19'sd256, 19'sd128, 19'sd64, 19'sd32, 19'sd16,
    19'sd8, 19'sd4, 19'sd2
  };

endpackage

// File: src/lik_delay.sv
module lik_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [D];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < D; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[D-1];

endmodule

// File: src/lik_sqrt.sv
module lik_sqrt #(
  parameter int RW = 18
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  // one result bit per cell, two radicand bits consumed per cell
  logic [2*RW-1:0] rad_s  [RW];
  logic [RW-1:0]   root_s [RW];
  logic [RW+1:0]   rem_s  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_cell
    logic [2*RW-1:0] rad_in;
    logic [RW-1:0]   root_in;
    logic [RW+1:0]   rem_in;
    logic [RW+1:0]   remc;
    logic [RW+1:0]   trial;
    logic            take;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign rad_in  = rad_s[i-1];
      assign root_in = root_s[i-1];
      assign rem_in  = rem_s[i-1];
    end

    assign remc  = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign take  = (remc >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[i]  <= rad_in << 2;
        root_s[i] <= {root_in[RW-2:0], take};
        rem_s[i]  <= take ? (remc - trial) : remc;
      end
    end
  end

  assign root = root_s[RW-1];

endmodule

// File: src/lik_div.sv
module lik_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [lik_pkg::DIV_W-1:0] mag,
  input  logic [lik_pkg::DIV_W-1:0] den,
  output logic [lik_pkg::QW-1:0]    quo
);
  import lik_pkg::*;

  // floor(mag * 2^16 / den), mag <= den; one quotient bit per cell
  logic [DIV_W:0]   rem_s [QW];
  logic [DIV_W-1:0] den_s [QW];
  logic [QW-1:0]    q_s   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_cell
    logic [DIV_W:0]   rem_in;
    logic [DIV_W-1:0] den_in;
    logic [QW-1:0]    q_in;
    logic [DIV_W:0]   remd;
    logic             take;

    if (i == 0) begin : g_first
      assign rem_in = {1'b0, mag};
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_s[i-1];
      assign den_in = den_s[i-1];
      assign q_in   = q_s[i-1];
    end

    assign take = (rem_in >= {1'b0, den_in});
    assign remd = take ? (rem_in - {1'b0, den_in}) : rem_in;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i] <= {remd[DIV_W-1:0], 1'b0};
        den_s[i] <= den_in;
        q_s[i]   <= {q_in[QW-2:0], take};
      end
    end
  end

  assign quo = q_s[QW-1];

endmodule

// File: src/lik_atan.sv
module lik_atan (
  input  logic                          clk,
  input  logic                          en,
  input  logic [lik_pkg::ATAN_IN_W-1:0] a,
  input  logic [lik_pkg::ATAN_IN_W-1:0] b,
  output logic [lik_pkg::ANG_W-1:0]     ang
);
  import lik_pkg::*;

  // atan2(a, b) for a, b >= 0: normalize, CORDIC vectoring, clamp
  logic [NORM_W-1:0]          na_s [NORM_STEPS];
  logic [NORM_W-1:0]          nb_s [NORM_STEPS];
  logic signed [CORDIC_W-1:0] x_s  [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_s  [CORDIC_STEPS];
  logic signed [Z_W-1:0]      z_s  [CORDIC_STEPS];
  logic [ANG_W-1:0]           ang_r;

  // binary leading-zero shift, largest step first
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int SH = 1 << (NORM_STEPS - 1 - k);
    logic [NORM_W-1:0] na_in;
    logic [NORM_W-1:0] nb_in;
    logic              top_zero;

    if (k == 0) begin : g_first
      assign na_in = NORM_W'(a);
      assign nb_in = NORM_W'(b);
    end else begin : g_next
      assign na_in = na_s[k-1];
      assign nb_in = nb_s[k-1];
    end

    assign top_zero = (((na_in | nb_in) >> (NORM_W - SH)) == '0);

    always_ff @(posedge clk) begin
      if (en) begin
        na_s[k] <= top_zero ? (na_in << SH) : na_in;
        nb_s[k] <= top_zero ? (nb_in << SH) : nb_in;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CORDIC_W-1:0] x_in;
    logic signed [CORDIC_W-1:0] y_in;
    logic signed [Z_W-1:0]      z_in;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;

    if (i == 0) begin : g_first
      assign x_in = $signed({{(CORDIC_W-NORM_W){1'b0}}, nb_s[NORM_STEPS-1]});
      assign y_in = $signed({{(CORDIC_W-NORM_W){1'b0}}, na_s[NORM_STEPS-1]});
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_s[i-1];
      assign y_in = y_s[i-1];
      assign z_in = z_s[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_in > 0) begin
          x_s[i] <= x_in + dx;
          y_s[i] <= y_in - dy;
          z_s[i] <= z_in + ATAN_TAB[i];
        end else begin
          x_s[i] <= x_in - dx;
          y_s[i] <= y_in + dy;
          z_s[i] <= z_in - ATAN_TAB[i];
        end
      end
    end
  end

  // clamp into [0, pi/2]; a zero vector ends up negative and reads 0
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (z_s[CORDIC_STEPS-1] < 0) begin
        ang_r <= '0;
      end else if (z_s[CORDIC_STEPS-1] > HALF_PI_Q16) begin
        ang_r <= ANG_W'(HALF_PI_Q16);
      end else begin
        ang_r <= z_s[CORDIC_STEPS-1][ANG_W-1:0];
      end
    end
  end

  assign ang = ang_r;

endmodule

// File: src/leg_inverse_kinematics.sv
// Throughput: one item per cycle; the whole pipeline holds while a finished
// result is stalled at the output register.
// Depth is set by the chain of square-root, divider and CORDIC cells.
// Reset (rst, synchronous, active high) empties the pipeline and loads the
// default link lengths into the configuration registers.
module leg_inverse_kinematics (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] pos_x,
  input  logic signed [17:0] pos_y,
  input  logic signed [17:0] pos_z,
  input  logic [1:0]         leg_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] abduction_angle,
  output logic signed [15:0] hip_angle,
  output logic signed [15:0] knee_angle,
  output logic               unreachable,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import lik_pkg::*;

  // ---------------------------------------------------------------------
  // Timeline by stage (stage n = n-th register after acceptance)
  //   1  abs values and squares      2  lyz2 = y^2+z^2-h^2, clamp
  //   3  lxzp2 = lyz2 + x^2          4  acos numerators
  //   5  |num1|                      6  clamp num1 against 2*hu*hl
  //   T_LYZ / T_LXZ: floor square roots out of the wide sqrt chain
  //   T_C2: clamp of second acos argument, needs lxzp for its denominator
  //   acos: square, 1 - c^2, narrow sqrt chain, atan chain, pi fold
  //   T_FIN: angle differences, then Q2.13 rounding into output register
  // ---------------------------------------------------------------------
  localparam int ACOS_LAT = 2 + SQ_NARROW_W + LAT_ATAN + 1;
  localparam int T_LYZ    = 2 + SQ_WIDE_W;
  localparam int T_LXZ    = 3 + SQ_WIDE_W;
  localparam int T_C1     = 6;
  localparam int T_Q1     = T_C1 + QW;
  localparam int T_A1     = T_Q1 + ACOS_LAT;
  localparam int T_C2     = T_LXZ + 2;
  localparam int T_Q2     = T_C2 + QW;
  localparam int T_A2     = T_Q2 + ACOS_LAT;
  localparam int T_FIN    = T_A2 + 1;
  localparam int LAT      = T_FIN + 1;

  // configuration registers
  logic [15:0] abd_off;
  logic [15:0] upper_len;
  logic [15:0] lower_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      abd_off   <= ABD_OFFSET_RST;
      upper_len <= UPPER_LEN_RST;
      lower_len <= LOWER_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ABD_OFFSET: abd_off   <= cfg_data;
        CFG_UPPER_LEN:  upper_len <= cfg_data;
        CFG_LOWER_LEN:  lower_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // Products of the link lengths. Config is to change only while idle;
  // the block does not enforce it. These then settle long before an item reads them.
  logic [31:0]        h2;
  logic [31:0]        hu2;
  logic [31:0]        hl2;
  logic [32:0]        sumsq;
  logic signed [32:0] diffsq;
  logic [32:0]        den1;

  always_ff @(posedge clk) begin
    h2     <= 32'(abd_off) * 32'(abd_off);
    hu2    <= 32'(upper_len) * 32'(upper_len);
    hl2    <= 32'(lower_len) * 32'(lower_len);
    den1   <= {32'(upper_len) * 32'(lower_len), 1'b0};
    sumsq  <= 33'(hu2) + 33'(hl2);
    diffsq <= $signed(33'(hu2)) - $signed(33'(hl2));
  end

  // pipeline advance: freeze everything while the result is held
  logic adv;
  logic [LAT-1:0] vld;

  assign adv       = !(vld[LAT-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // ---- stage 1: magnitudes and squares ----
  logic [17:0] xa_c, ya_c, za_c;
  logic [17:0] xa, ya, za;
  logic        odd;
  logic [35:0] x2, y2, z2;

  assign xa_c = pos_x[17] ? 18'(-pos_x) : 18'(pos_x);
  assign ya_c = pos_y[17] ? 18'(-pos_y) : 18'(pos_y);
  assign za_c = pos_z[17] ? 18'(-pos_z) : 18'(pos_z);

  always_ff @(posedge clk) begin
    if (adv) begin
      xa  <= xa_c;
      ya  <= ya_c;
      za  <= za_c;
      odd <= leg_index[0];
      x2  <= 36'(xa_c) * 36'(xa_c);
      y2  <= 36'(ya_c) * 36'(ya_c);
      z2  <= 36'(za_c) * 36'(za_c);
    end
  end

  // ---- stage 2: lateral plane, negative lyz2 is out of reach ----
  logic signed [36:0] lyz2_c;
  logic [35:0]        lyz2;
  logic [35:0]        x2_d;
  logic               f0;

  assign lyz2_c = $signed(37'(y2) + 37'(z2) - 37'(h2));

  always_ff @(posedge clk) begin
    if (adv) begin
      lyz2 <= lyz2_c[36] ? '0 : lyz2_c[35:0];
      f0   <= lyz2_c[36];
      x2_d <= x2;
    end
  end

  // ---- stage 3: sagittal distance squared ----
  logic [35:0] lxzp2;

  always_ff @(posedge clk) begin
    if (adv) begin
      lxzp2 <= lyz2 + x2_d;
    end
  end

  // ---- stage 4: law-of-cosines numerators ----
  logic signed [37:0] num1, num2;

  always_ff @(posedge clk) begin
    if (adv) begin
      num1 <= $signed({2'b00, lxzp2}) - $signed({5'b0, sumsq});
      num2 <= $signed({2'b00, lxzp2}) + $signed({{5{diffsq[32]}}, diffsq});
    end
  end

  // ---- stages 5, 6: knee argument, magnitude then clamp ----
  logic [36:0]       mag1;
  logic              neg1, neg1_c;
  logic [DIV_W-1:0]  m1, d1;
  logic              f1;

  always_ff @(posedge clk) begin
    if (adv) begin
      neg1 <= num1[37];
      mag1 <= num1[37] ? 37'(-num1) : 37'(num1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (den1 == '0) begin
        // degenerate triangle: argument plus one, angle zero
        neg1_c <= 1'b0;
        m1     <= DIV_W'(1);
        d1     <= DIV_W'(1);
        f1     <= 1'b1;
      end else if (mag1 > 37'(den1)) begin
        neg1_c <= neg1;
        m1     <= DIV_W'(den1);
        d1     <= DIV_W'(den1);
        f1     <= 1'b1;
      end else begin
        // a quotient that truncates to zero carries no sign
        neg1_c <= neg1 && ({mag1, 16'b0} >= 53'(den1));
        m1     <= mag1[DIV_W-1:0];
        d1     <= DIV_W'(den1);
        f1     <= 1'b0;
      end
    end
  end

  // ---- square roots of lyz2 and lxzp2 ----
  logic [SQ_WIDE_W-1:0] lyz, lxzp;

  lik_sqrt #(.RW(SQ_WIDE_W)) u_sqrt_lyz (
    .clk(clk), .en(adv), .rad(lyz2), .root(lyz)
  );

  lik_sqrt #(.RW(SQ_WIDE_W)) u_sqrt_lxzp (
    .clk(clk), .en(adv), .rad(lxzp2), .root(lxzp)
  );

  // ---- hip argument: denominator 2*hu*lxzp ----
  logic signed [37:0] num2_d;
  logic [DIV_W-1:0]   den2;
  logic [36:0]        mag2;
  logic               neg2, neg2_c;
  logic [DIV_W-1:0]   m2, d2;
  logic               f2;

  lik_delay #(.W(38), .D(T_LXZ - 4)) u_dly_num2 (
    .clk(clk), .en(adv), .d(num2), .q(num2_d)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      den2 <= {34'(upper_len) * 34'(lxzp), 1'b0};
      neg2 <= num2_d[37];
      mag2 <= num2_d[37] ? 37'(-num2_d) : 37'(num2_d);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (den2 == '0) begin
        neg2_c <= 1'b0;
        m2     <= DIV_W'(1);
        d2     <= DIV_W'(1);
        f2     <= 1'b1;
      end else if (mag2 > 37'(den2)) begin
        neg2_c <= neg2;
        m2     <= den2;
        d2     <= den2;
        f2     <= 1'b1;
      end else begin
        neg2_c <= neg2 && ({mag2, 16'b0} >= 53'(den2));
        m2     <= mag2[DIV_W-1:0];
        d2     <= den2;
        f2     <= 1'b0;
      end
    end
  end

  // ---- dividers: |num| * 2^16 / den ----
  logic [QW-1:0] q1, q2;

  lik_div u_div1 (.clk(clk), .en(adv), .mag(m1), .den(d1), .quo(q1));
  lik_div u_div2 (.clk(clk), .en(adv), .mag(m2), .den(d2), .quo(q2));

  // ---- acos of knee argument: atan2(sqrt(1 - c^2), |c|) ----
  logic [33:0]            sq1, v1;
  logic [SQ_NARROW_W-1:0] s1;
  logic [QW-1:0]          q1_d;
  logic                   neg1_d;
  logic [ANG_W-1:0]       at1;
  logic [17:0]            acos1, acos1_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq1 <= 34'(q1) * 34'(q1);
      v1  <= ONE_SQ - sq1;
    end
  end

  lik_sqrt #(.RW(SQ_NARROW_W)) u_sqrt_c1 (
    .clk(clk), .en(adv), .rad(v1), .root(s1)
  );

  lik_delay #(.W(QW), .D(2 + SQ_NARROW_W)) u_dly_q1 (
    .clk(clk), .en(adv), .d(q1), .q(q1_d)
  );

  lik_delay #(.W(1), .D(T_A1 - 1 - T_C1)) u_dly_neg1 (
    .clk(clk), .en(adv), .d(neg1_c), .q(neg1_d)
  );

  lik_atan u_atan_c1 (
    .clk(clk), .en(adv), .a(ATAN_IN_W'(s1)), .b(ATAN_IN_W'(q1_d)), .ang(at1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      acos1 <= neg1_d ? (PI_Q16 - 18'(at1)) : 18'(at1);
    end
  end

  lik_delay #(.W(18), .D(T_A2 - T_A1)) u_dly_acos1 (
    .clk(clk), .en(adv), .d(acos1), .q(acos1_d)
  );

  // ---- acos of hip argument ----
  logic [33:0]            sq2, v2;
  logic [SQ_NARROW_W-1:0] s2;
  logic [QW-1:0]          q2_d;
  logic                   neg2_d;
  logic [ANG_W-1:0]       at2;
  logic [17:0]            acos2;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq2 <= 34'(q2) * 34'(q2);
      v2  <= ONE_SQ - sq2;
    end
  end

  lik_sqrt #(.RW(SQ_NARROW_W)) u_sqrt_c2 (
    .clk(clk), .en(adv), .rad(v2), .root(s2)
  );

  lik_delay #(.W(QW), .D(2 + SQ_NARROW_W)) u_dly_q2 (
    .clk(clk), .en(adv), .d(q2), .q(q2_d)
  );

  lik_delay #(.W(1), .D(T_A2 - 1 - T_C2)) u_dly_neg2 (
    .clk(clk), .en(adv), .d(neg2_c), .q(neg2_d)
  );

  lik_atan u_atan_c2 (
    .clk(clk), .en(adv), .a(ATAN_IN_W'(s2)), .b(ATAN_IN_W'(q2_d)), .ang(at2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      acos2 <= neg2_d ? (PI_Q16 - 18'(at2)) : 18'(at2);
    end
  end

  // ---- direct atan2 terms ----
  logic [17:0]      xa_d;
  logic [ANG_W-1:0] athl, atxl, atyz;
  logic [ANG_W-1:0] athl_d, atxl_d, atyz_d;

  lik_delay #(.W(18), .D(T_LYZ - 1)) u_dly_x (
    .clk(clk), .en(adv), .d(xa), .q(xa_d)
  );

  lik_atan u_atan_hl (
    .clk(clk), .en(adv), .a(ATAN_IN_W'(abd_off)), .b(lyz), .ang(athl)
  );

  lik_atan u_atan_xl (
    .clk(clk), .en(adv), .a(xa_d), .b(lyz), .ang(atxl)
  );

  lik_atan u_atan_yz (
    .clk(clk), .en(adv), .a(ya), .b(za), .ang(atyz)
  );

  lik_delay #(.W(ANG_W), .D(T_A2 - T_LYZ - LAT_ATAN)) u_dly_athl (
    .clk(clk), .en(adv), .d(athl), .q(athl_d)
  );

  lik_delay #(.W(ANG_W), .D(T_A2 - T_LYZ - LAT_ATAN)) u_dly_atxl (
    .clk(clk), .en(adv), .d(atxl), .q(atxl_d)
  );

  lik_delay #(.W(ANG_W), .D(T_A2 - 1 - LAT_ATAN)) u_dly_atyz (
    .clk(clk), .en(adv), .d(atyz), .q(atyz_d)
  );

  // ---- side signals to the final stage ----
  logic odd_d, f0_d, f1_d, f2_d;

  lik_delay #(.W(1), .D(T_A2 - 1)) u_dly_odd (
    .clk(clk), .en(adv), .d(odd), .q(odd_d)
  );

  lik_delay #(.W(1), .D(T_A2 - 2)) u_dly_f0 (
    .clk(clk), .en(adv), .d(f0), .q(f0_d)
  );

  lik_delay #(.W(1), .D(T_A2 - T_C1)) u_dly_f1 (
    .clk(clk), .en(adv), .d(f1), .q(f1_d)
  );

  lik_delay #(.W(1), .D(T_A2 - T_C2)) u_dly_f2 (
    .clk(clk), .en(adv), .d(f2), .q(f2_d)
  );

  // ---- final: angle differences, side sign on abduction ----
  logic signed [18:0] hip_s;
  logic signed [17:0] gam_s;
  logic [17:0]        knee_s;
  logic               flag_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      hip_s  <= $signed({2'b00, atxl_d}) - $signed({1'b0, acos2});
      // odd legs take -gamma
      gam_s  <= odd_d ? ($signed({1'b0, atyz_d}) - $signed({1'b0, athl_d}))
                      : ($signed({1'b0, athl_d}) - $signed({1'b0, atyz_d}));
      knee_s <= acos1_d;
      flag_s <= f0_d | f1_d | f2_d;
    end
  end

  // ---- output register: round Q.16 to Q2.13 ----
  logic signed [19:0] hip_rnd, gam_rnd, knee_rnd;

  assign hip_rnd  = $signed({hip_s[18], hip_s}) + 20'sd4;
  assign gam_rnd  = $signed({{2{gam_s[17]}}, gam_s}) + 20'sd4;
  assign knee_rnd = $signed({2'b00, knee_s}) + 20'sd4;

  always_ff @(posedge clk) begin
    if (adv) begin
      abduction_angle <= gam_rnd[18:3];
      hip_angle       <= hip_rnd[18:3];
      knee_angle      <= knee_rnd[18:3];
      unreachable     <= flag_s;
    end
  end

`ifndef SYNTHESIS
  // an accepted item always enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted item did not enter the pipeline");

  // a held result freezes the whole valid chain
  a_hold_freezes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(vld))
    else $error("pipeline moved while result held");

  // items move one stage per advancing cycle, none created or dropped
  a_chain_shift: assert property (@(posedge clk) disable iff (rst)
    adv |=> vld[LAT-1] == $past(vld[LAT-2]))
    else $error("valid chain skipped a stage");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import lik_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 120;   // longer than the pipeline latency
  localparam int LONG_HOLD      = 400;   // receiver hold-off, longer than the pipe

  localparam longint PI_Q16_L      = 205887;
  localparam longint HALF_PI_Q16_L = 102944;

  typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
    logic [1:0]         leg;
  } foot_t;

  typedef struct {
    logic signed [15:0] abd;
    logic signed [15:0] hip;
    logic signed [15:0] knee;
    logic               unr;
  } joints_t;

  logic clk;
  logic rst;
  logic in_valid, in_stall;
  logic signed [17:0] pos_x, pos_y, pos_z;
  logic [1:0] leg_index;
  logic out_valid, out_stall;
  logic signed [15:0] abduction_angle, hip_angle, knee_angle;
  logic unreachable;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  leg_inverse_kinematics u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .leg_index(leg_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .abduction_angle(abduction_angle), .hip_angle(hip_angle),
    .knee_angle(knee_angle), .unreachable(unreachable),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // testbench copy of the link geometry registers
  longint abd_ofs_m, upper_len_m, lower_len_m;

  foot_t   foot_queue[$];
  joints_t joints_queue[$];
  int      mismatches;
  int      sender_idle_pct, recv_stall_pct;
  bit      pressure_arm;

  // ---------------------------------------------------------------------------
  // Joint angle predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // first-quadrant atan2 by CORDIC vectoring, Q.16 radians
  function automatic longint angle_of(longint unsigned a, longint unsigned b);
    longint tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2};
    longint cx, cy, cz, dx, dy;
    if (a == 0 && b == 0) return 0;
    while (a < (64'd1 << 30) && b < (64'd1 << 30)) begin
      a = a << 1;
      b = b << 1;
    end
    cx = longint'(b);
    cy = longint'(a);
    cz = 0;
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;   // arithmetic shift floors
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; cz += tab[i];
      end else begin
        cx -= dx; cy += dy; cz -= tab[i];
      end
    end
    if (cz < 0) cz = 0;
    if (cz > HALF_PI_Q16_L) cz = HALF_PI_Q16_L;
    return cz;
  endfunction

  function automatic longint arccos_q16(longint c);
    longint unsigned mag, s;
    longint t;
    mag = (c < 0) ? -c : c;
    s = sqrt_floor((64'd1 << 32) - mag * mag);
    t = angle_of(s, mag);
    return (c < 0) ? PI_Q16_L - t : t;
  endfunction

  // law-of-cosines ratio, clamped to +-1 with the flag raised
  function automatic longint cos_ratio(longint num, longint unsigned den, inout bit flag);
    longint unsigned mag;
    longint r;
    if (den == 0) begin
      flag = 1'b1;
      return 65536;
    end
    mag = (num < 0) ? -num : num;
    if (mag > den) begin
      flag = 1'b1;
      mag = den;
    end
    r = longint'((mag << 16) / den);
    return (num < 0) ? -r : r;
  endfunction

  function automatic logic signed [15:0] round_q13(longint v);
    longint r;
    r = (v + 4) >>> 3;
    return r[15:0];
  endfunction

  function automatic joints_t solve_leg(foot_t f);
    joints_t j;
    longint px, py, pz, h, hu, hl, lyz2, lxzp2, gamma, c1, c2, knee, hip;
    longint unsigned ax, ay, az, lyz, lxzp;
    bit flag;
    px = longint'(f.x); py = longint'(f.y); pz = longint'(f.z);
    ax = (px < 0) ? -px : px;
    ay = (py < 0) ? -py : py;
    az = (pz < 0) ? -pz : pz;
    h = abd_ofs_m; hu = upper_len_m; hl = lower_len_m;
    flag = 1'b0;
    lyz2 = longint'(ay * ay + az * az) - h * h;
    if (lyz2 < 0) begin
      lyz2 = 0;
      flag = 1'b1;
    end
    lyz = sqrt_floor(lyz2);
    lxzp2 = lyz2 + longint'(ax * ax);
    lxzp = sqrt_floor(lxzp2);
    gamma = angle_of(h, lyz) - angle_of(ay, az);
    c1 = cos_ratio(lxzp2 - hl * hl - hu * hu, 2 * hu * hl, flag);
    knee = arccos_q16(c1);
    c2 = cos_ratio(lxzp2 + hu * hu - hl * hl, 2 * longint'(hu) * lxzp, flag);
    hip = angle_of(ax, lyz) - arccos_q16(c2);
    j.abd  = round_q13(f.leg[0] ? -gamma : gamma);
    j.hip  = round_q13(hip);
    j.knee = round_q13(knee);
    j.unr  = flag;
    return j;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued foot targets, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        joints_queue.push_back(solve_leg('{pos_x, pos_y, pos_z, leg_index}));
      // payload may only move when nothing is held
      if (!in_valid || !in_stall) begin
        if (foot_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          foot_t f;
          f = foot_queue.pop_front();
          in_valid  <= 1'b1;
          pos_x     <= f.x;
          pos_y     <= f.y;
          pos_z     <= f.z;
          leg_index <= f.leg;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results, drives stall, does the long hold-off
  // ---------------------------------------------------------------------------
  int hold_left;
  bit pressure_done;

  always @(posedge clk) begin
    if (rst) begin
      out_stall     <= 1'b0;
      hold_left     <= 0;
      pressure_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (joints_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result item with no expectation: abd %0d hip %0d knee %0d unr %0b",
                     abduction_angle, hip_angle, knee_angle, unreachable);
        end else begin
          joints_t e;
          e = joints_queue.pop_front();
          if (e.abd !== abduction_angle || e.hip !== hip_angle ||
              e.knee !== knee_angle || e.unr !== unreachable) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp abd %0d hip %0d knee %0d unr %0b, got %0d %0d %0d %0b",
                       e.abd, e.hip, e.knee, e.unr,
                       abduction_angle, hip_angle, knee_angle, unreachable);
          end
        end
      end
      if (pressure_arm && !pressure_done) begin
        pressure_done <= 1'b1;
        hold_left     <= LONG_HOLD;
        out_stall     <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog: cycles with no handshake on any port
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ABD_OFFSET: abd_ofs_m   = longint'(v);
      CFG_UPPER_LEN:  upper_len_m = longint'(v);
      CFG_LOWER_LEN:  lower_len_m = longint'(v);
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [15:0] h, logic [15:0] hu, logic [15:0] hl);
    write_reg(CFG_ABD_OFFSET, h);
    write_reg(CFG_UPPER_LEN, hu);
    write_reg(CFG_LOWER_LEN, hl);
  endtask

  task automatic add_foot(int x, int y, int z, int leg);
    foot_t f;
    f.x = 18'(x); f.y = 18'(y); f.z = 18'(z); f.leg = 2'(leg);
    foot_queue.push_back(f);
  endtask

  // mostly targets inside the leg's workspace, some anywhere in range
  task automatic add_random_feet(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        add_foot($urandom, $urandom, $urandom, $urandom);
      else
        add_foot($urandom_range(60000) - 30000, $urandom_range(50000) - 25000,
                 -$urandom_range(30000), $urandom_range(3));
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (foot_queue.size() != 0 || in_valid || joints_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; pos_x = '0; pos_y = '0; pos_z = '0; leg_index = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_ABD_OFFSET; cfg_data = '0;
    mismatches = 0; sender_idle_pct = 0; recv_stall_pct = 0; pressure_arm = 1'b0;
    abd_ofs_m = longint'(ABD_OFFSET_RST);
    upper_len_m = longint'(UPPER_LEN_RST);
    lower_len_m = longint'(LOWER_LEN_RST);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset geometry, extremes and the clamp cases
    add_foot(0, 0, 0, 0);                         // negative lyz2 clamp
    add_foot(131071, 131071, 131071, 1);          // far out of reach
    add_foot(-131072, -131072, -131072, 2);
    add_foot(-131072, 131071, -131072, 3);
    add_foot(0, 4063, 0, 0);                      // lyz exactly zero
    add_foot(0, 4063, -26477, 1);                 // leg fully stretched
    add_foot(0, 4000, -1000, 2);                  // folded too tight
    add_foot(5000, -4063, -20000, 3);
    add_foot(-8000, 3000, -22000, 0);
    add_foot(10000, 0, 0, 1);
    add_foot(0, 20000, 0, 2);
    add_foot(0, 0, -20000, 3);
    add_foot(1, -1, 1, 1);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_geometry(ABD_OFFSET_RST, UPPER_LEN_RST, LOWER_LEN_RST);
        1: set_geometry(16'd0, 16'd65535, 16'd65535);
        2: set_geometry(16'd65535, 16'd0, 16'd12780);   // zero thigh: zero divisor
        3: set_geometry(16'd4063, 16'd13697, 16'd0);
        4: set_geometry(16'd0, 16'd0, 16'd0);
        default: set_geometry(16'($urandom_range(8000)), 16'($urandom_range(10000, 20000)),
                              16'($urandom_range(10000, 20000)));
      endcase
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin sender_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (ph == 4) begin
        sender_idle_pct = 0; recv_stall_pct = 0;
        pressure_arm = 1'b1;   // receiver holds off while the pipe fills
      end
      add_random_feet(200);
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/lik_pkg.sv
src/lik_delay.sv
src/lik_sqrt.sv
src/lik_div.sv
src/lik_atan.sv
src/leg_inverse_kinematics.sv
tb/tb.sv
